// ===== sv/vpp_pkg.sv =====
// Package for the vertex projection block: word types, codes and
// single-precision arithmetic helpers split at pipeline register boundaries.
// No dependencies.
`default_nettype none

package vpp_pkg;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_POINT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_WCLIP  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FK_NUM = 2'd0,
		FK_INF = 2'd1,
		FK_NAN = 2'd2
	} fkind_t;

	typedef enum logic [1:0] {
		RK_NUM  = 2'd0,
		RK_ZERO = 2'd1,
		RK_INF  = 2'd2
	} rkind_t;

	localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
	localparam logic [31:0] FP_HALF = 32'h3F00_0000;
	localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
	localparam logic [31:0] FP_ZERO = 32'h0000_0000;

	typedef struct packed {
		op_t         op;
		logic [3:0]  matrix_index;
		logic [31:0] matrix_value;
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [31:0] point_z;
		logic        batch_last_in;
	} in_word_t;

	typedef struct packed {
		logic [31:0] screen_x;
		logic [31:0] screen_y;
		logic [31:0] depth;
		logic        visible;
		logic        batch_last_out;
	} out_word_t;

	// value = sig * 2^(ex - 176) before rounding; sticky folded into a low bit of sig
	typedef struct packed {
		fkind_t             kind;
		logic               sgn;
		logic signed [11:0] ex;
		logic [49:0]        sig;
	} pre_t;

	// normalized divisor: value = man * 2^(ex - 150), man[23] set when RK_NUM
	typedef struct packed {
		rkind_t            kind;
		logic              sgn;
		logic [23:0]       man;
		logic signed [9:0] ex;
	} rcp_in_t;

	function automatic logic [5:0] clz50(logic [49:0] v);
		logic [5:0] n;
		n = 6'd50;
		for (int i = 0; i < 50; i++) begin
			if (v[i]) n = 6'(49 - i);
		end
		return n;
	endfunction

	function automatic pre_t fp_mul_a(logic [31:0] a, logic [31:0] b);
		logic [7:0]  ea, eb;
		logic [23:0] ma, mb;
		logic        an, bn, ai, bi, az, bz;
		logic [47:0] prod;
		pre_t        p;
		ea = a[30:23];
		eb = b[30:23];
		ma = {ea != 8'h00, a[22:0]};
		mb = {eb != 8'h00, b[22:0]};
		an = (ea == 8'hFF) && (a[22:0] != 23'd0);
		bn = (eb == 8'hFF) && (b[22:0] != 23'd0);
		ai = (ea == 8'hFF) && (a[22:0] == 23'd0);
		bi = (eb == 8'hFF) && (b[22:0] == 23'd0);
		az = a[30:0] == 31'd0;
		bz = b[30:0] == 31'd0;
		prod = 48'(ma) * 48'(mb);
		p.sgn = a[31] ^ b[31];
		p.sig = {prod, 2'b00};
		p.ex = $signed({4'b0, (ea == 8'h00) ? 8'd1 : ea})
			+ $signed({4'b0, (eb == 8'h00) ? 8'd1 : eb}) - 12'sd126;
		if (an || bn || (ai && bz) || (bi && az)) p.kind = FK_NAN;
		else if (ai || bi) p.kind = FK_INF;
		else p.kind = FK_NUM;
		return p;
	endfunction

	function automatic pre_t fp_add_a(logic [31:0] a, logic [31:0] b);
		logic [31:0] big, sml;
		logic [7:0]  eb, es, d;
		logic [4:0]  dc;
		logic [26:0] big27, sml27, al;
		logic [53:0] tmp;
		logic [27:0] sum;
		logic        an, bn, ai, bi;
		pre_t        p;
		an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
		es = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
		big27 = {big[30:23] != 8'h00, big[22:0], 3'b000};
		sml27 = {sml[30:23] != 8'h00, sml[22:0], 3'b000};
		d = eb - es;
		dc = (d > 8'd27) ? 5'd27 : d[4:0];
		tmp = {sml27, 27'd0} >> dc;
		al = tmp[53:27] | {26'd0, |tmp[26:0]};
		if (a[31] ^ b[31]) sum = {1'b0, big27} - {1'b0, al};
		else sum = {1'b0, big27} + {1'b0, al};
		p.sig = {sum, 22'd0};
		p.ex = $signed({4'b0, eb}) + 12'sd1;
		p.sgn = (sum == 28'd0) ? (a[31] & b[31]) : big[31];
		if (an || bn || (ai && bi && (a[31] != b[31]))) p.kind = FK_NAN;
		else if (ai || bi) p.kind = FK_INF;
		else p.kind = FK_NUM;
		return p;
	endfunction

	function automatic logic [31:0] fp_round(pre_t p);
		logic [5:0]         lz;
		logic signed [11:0] en, rsh;
		logic [49:0]        norm, lost;
		logic               st, inc;
		logic [7:0]         expf;
		logic [30:0]        base;
		logic [31:0]        res;
		lz = clz50(p.sig);
		en = p.ex - $signed({6'b0, lz});
		norm = p.sig;
		lost = '0;
		expf = '0;
		rsh = '0;
		res = FP_QNAN;
		unique case (p.kind)
			FK_NAN: res = FP_QNAN;
			FK_INF: res = {p.sgn, 8'hFF, 23'd0};
			default: begin
				if (p.sig == 50'd0) begin
					res = {p.sgn, 31'd0};
				end else begin
					if (en >= 12'sd1) begin
						norm = p.sig << lz;
						expf = en[7:0];
					end else if (p.ex >= 12'sd1) begin
						norm = p.sig << 6'(p.ex - 12'sd1);
					end else begin
						rsh = 12'sd1 - p.ex;
						if (rsh > 12'sd50) rsh = 12'sd50;
						{norm, lost} = {p.sig, 50'd0} >> rsh[5:0];
					end
					st = (|norm[24:0]) | (|lost);
					inc = norm[25] & (st | norm[26]);
					if (en >= 12'sd255) begin
						res = {p.sgn, 8'hFF, 23'd0};
					end else begin
						base = {expf, norm[48:26]} + 31'(inc);
						res = {p.sgn, base};
					end
				end
			end
		endcase
		return res;
	endfunction

	function automatic logic fp_gt(logic [31:0] a, logic [31:0] b);
		logic an, bn, r;
		an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (an || bn) r = 1'b0;
		else if (!a[31] && b[31]) r = !((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
		else if (a[31] && !b[31]) r = 1'b0;
		else if (!a[31]) r = a[30:0] > b[30:0];
		else r = a[30:0] < b[30:0];
		return r;
	endfunction

	function automatic rcp_in_t rcp_prep(logic [31:0] c);
		logic [7:0]  e;
		logic [22:0] f;
		logic [4:0]  lz;
		rcp_in_t     r;
		e = c[30:23];
		f = c[22:0];
		lz = '0;
		for (int i = 0; i < 23; i++) begin
			if (f[i]) lz = 5'(23 - i);
		end
		r.sgn = c[31];
		if (e == 8'h00) begin
			r.man = {1'b0, f} << lz;
			r.ex = 10'sd1 - $signed({5'b0, lz});
		end else begin
			r.man = {1'b1, f};
			r.ex = $signed({2'b0, e});
		end
		if (e == 8'hFF) r.kind = RK_INF;
		else if (c[30:0] == 31'd0) r.kind = RK_ZERO;
		else r.kind = RK_NUM;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/vpp_recip.sv =====
// Pipelined single-precision reciprocal: restoring division, two quotient
// bits per stage, then one rounding stage. Carries a side tag. Uses vpp_pkg.
`default_nettype none

module vpp_recip #(
	parameter int TAG_W = 98
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire vpp_pkg::rcp_in_t  op,
	input  wire logic [TAG_W-1:0]  tag,
	output logic                   out_valid,
	output logic [31:0]            iw,
	output logic [TAG_W-1:0]       out_tag
);
	import vpp_pkg::*;

	localparam int QBITS = 28;
	localparam int STEPS = 2;
	localparam int NSTG  = QBITS / STEPS;

	logic             v_s   [NSTG];
	logic [24:0]      rem_s [NSTG];
	logic [QBITS-1:0] quo_s [NSTG];
	rcp_in_t          op_s  [NSTG];
	logic [TAG_W-1:0] tag_s [NSTG];

	logic             v_q;
	logic [31:0]      iw_q;
	logic [TAG_W-1:0] tag_q;
	pre_t             pre;

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		logic [24:0]      r_in, r_nx;
		logic [QBITS-1:0] q_in, q_nx;
		rcp_in_t          o_in;
		logic [TAG_W-1:0] t_in;
		logic             v_in;

		if (g == 0) begin : g_first
			assign r_in = 25'h080_0000;
			assign q_in = '0;
			assign o_in = op;
			assign t_in = tag;
			assign v_in = in_valid;
		end else begin : g_rest
			assign r_in = rem_s[g-1];
			assign q_in = quo_s[g-1];
			assign o_in = op_s[g-1];
			assign t_in = tag_s[g-1];
			assign v_in = v_s[g-1];
		end

		always_comb begin
			r_nx = r_in;
			q_nx = q_in;
			for (int k = 0; k < STEPS; k++) begin
				if (r_nx >= {1'b0, o_in.man}) begin
					q_nx = {q_nx[QBITS-2:0], 1'b1};
					r_nx = r_nx - {1'b0, o_in.man};
				end else begin
					q_nx = {q_nx[QBITS-2:0], 1'b0};
				end
				r_nx = {r_nx[23:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g] <= 1'b0;
			else if (en) v_s[g] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= r_nx;
				quo_s[g] <= q_nx;
				op_s[g]  <= o_in;
				tag_s[g] <= t_in;
			end
		end
	end

	always_comb begin
		pre.sgn = op_s[NSTG-1].sgn;
		pre.ex = 12'sd254 - 12'(op_s[NSTG-1].ex);
		pre.sig = {quo_s[NSTG-1], 22'd0} | {49'd0, rem_s[NSTG-1] != 25'd0};
		pre.kind = FK_NUM;
		unique case (op_s[NSTG-1].kind)
			RK_ZERO: pre.kind = FK_INF;
			RK_INF:  pre.sig = '0;
			default: pre.kind = FK_NUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (en) v_q <= v_s[NSTG-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iw_q  <= fp_round(pre);
			tag_q <= tag_s[NSTG-1];
		end
	end

	assign out_valid = v_q;
	assign iw = iw_q;
	assign out_tag = tag_q;

endmodule

`default_nettype wire

// ===== sv/vertex_perspective_projection.sv =====
// Top level of the vertex projection pipeline: matrix store, clip transform,
// perspective divide and viewport map. Uses vpp_pkg and vpp_recip.
`default_nettype none

// Takes one word per cycle while the input is not stalled. A load word writes
// one matrix entry when it is accepted and gives no result; a point word gives
// one result word after it is accepted, through the chain of single-precision
// multiply, add and round stages and the 15-stage reciprocal unit. When the result
// register is full and stalled, the whole pipeline holds and the input is stalled.
// Write the configuration registers and the matrix before sending points.
module vertex_perspective_projection (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pt_valid,
	output logic                     pt_stall,
	input  wire vpp_pkg::in_word_t   pt_data,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output vpp_pkg::out_word_t       res_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	import vpp_pkg::*;

	localparam int TAG_W = 98;

	logic        en;
	logic [31:0] mat_q [16];
	logic [31:0] width_q, height_q, wclip_q;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic        last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8;
	pre_t        prd_s1 [12];
	logic [31:0] bias_s1 [4];
	logic [31:0] p_s2 [12];
	logic [31:0] bias_s2 [4];
	pre_t        sum_s3 [4];
	logic [31:0] p2_s3 [4];
	logic [31:0] bias_s3 [4];
	logic [31:0] s_s4 [4];
	logic [31:0] p2_s4 [4];
	logic [31:0] bias_s4 [4];
	pre_t        sum_s5 [4];
	logic [31:0] bias_s5 [4];
	logic [31:0] s_s6 [4];
	logic [31:0] bias_s6 [4];
	pre_t        sum_s7 [4];
	logic [31:0] clip_s8 [4];

	logic             rcp_valid;
	logic [31:0]      rcp_iw;
	logic [TAG_W-1:0] rcp_tag_in, rcp_tag;
	logic [31:0]      r_cx, r_cy, r_cz;
	logic             r_vis, r_last;

	logic        v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18;
	logic        vis_s10, vis_s11, vis_s12, vis_s13, vis_s14, vis_s15, vis_s16, vis_s17;
	logic        vis_s18;
	logic        last_s10, last_s11, last_s12, last_s13, last_s14, last_s15, last_s16;
	logic        last_s17, last_s18;
	pre_t        m_s10 [3];
	logic [31:0] t_s11 [3];
	pre_t        h_s12 [2];
	logic [31:0] dz_s12, dz_s13, dz_s14, dz_s15, dz_s16, dz_s17, dz_s18;
	logic [31:0] t_s13 [2];
	pre_t        a_s14 [2];
	logic [31:0] t_s15 [2];
	pre_t        x_s16, y_s16;
	logic [31:0] x_s17, y_s17, x_s18;
	pre_t        y_s18;

	out_word_t   res_q;
	logic        res_valid_q;

	assign en = !(res_valid_q && res_stall);
	assign pt_stall = !en;
	assign res_valid = res_valid_q;
	assign res_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			wclip_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_WCLIP:  wclip_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pt_valid && en && pt_data.op == OP_LOAD) begin
			mat_q[pt_data.matrix_index] <= pt_data.matrix_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0;
			v_s14 <= 1'b0; v_s15 <= 1'b0; v_s16 <= 1'b0; v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pt_valid && pt_data.op == OP_POINT;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s10 <= rcp_valid; v_s11 <= v_s10; v_s12 <= v_s11; v_s13 <= v_s12;
			v_s14 <= v_s13; v_s15 <= v_s14; v_s16 <= v_s15; v_s17 <= v_s16;
			v_s18 <= v_s17;
			res_valid_q <= v_s18;
		end
	end

	// clip transform: products, then three adds left to right
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				prd_s1[r]     <= fp_mul_a(mat_q[r], pt_data.point_x);
				prd_s1[4 + r] <= fp_mul_a(mat_q[4 + r], pt_data.point_y);
				prd_s1[8 + r] <= fp_mul_a(mat_q[8 + r], pt_data.point_z);
				bias_s1[r]    <= mat_q[12 + r];
			end
			for (int i = 0; i < 12; i++) begin
				p_s2[i] <= fp_round(prd_s1[i]);
			end
			for (int r = 0; r < 4; r++) begin
				bias_s2[r] <= bias_s1[r];
				sum_s3[r]  <= fp_add_a(p_s2[r], p_s2[4 + r]);
				p2_s3[r]   <= p_s2[8 + r];
				bias_s3[r] <= bias_s2[r];
				s_s4[r]    <= fp_round(sum_s3[r]);
				p2_s4[r]   <= p2_s3[r];
				bias_s4[r] <= bias_s3[r];
				sum_s5[r]  <= fp_add_a(s_s4[r], p2_s4[r]);
				bias_s5[r] <= bias_s4[r];
				s_s6[r]    <= fp_round(sum_s5[r]);
				bias_s6[r] <= bias_s5[r];
				sum_s7[r]  <= fp_add_a(s_s6[r], bias_s6[r]);
				clip_s8[r] <= fp_round(sum_s7[r]);
			end
			last_s1 <= pt_data.batch_last_in;
			last_s2 <= last_s1; last_s3 <= last_s2; last_s4 <= last_s3;
			last_s5 <= last_s4; last_s6 <= last_s5; last_s7 <= last_s6;
			last_s8 <= last_s7;
		end
	end

	assign rcp_tag_in = {clip_s8[0], clip_s8[1], clip_s8[2],
		fp_gt(clip_s8[3], wclip_q), last_s8};

	vpp_recip #(
		.TAG_W (TAG_W)
	) u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.op        (rcp_prep(clip_s8[3])),
		.tag       (rcp_tag_in),
		.out_valid (rcp_valid),
		.iw        (rcp_iw),
		.out_tag   (rcp_tag)
	);

	assign {r_cx, r_cy, r_cz, r_vis, r_last} = rcp_tag;

	// viewport map
	always_ff @(posedge clk) begin
		if (en) begin
			m_s10[0] <= fp_mul_a(r_cx, rcp_iw);
			m_s10[1] <= fp_mul_a(r_cy, rcp_iw);
			m_s10[2] <= fp_mul_a(r_cz, rcp_iw);
			for (int i = 0; i < 3; i++) begin
				t_s11[i] <= fp_round(m_s10[i]);
			end
			for (int i = 0; i < 2; i++) begin
				h_s12[i] <= fp_mul_a(t_s11[i], FP_HALF);
				t_s13[i] <= fp_round(h_s12[i]);
				a_s14[i] <= fp_add_a(t_s13[i], FP_HALF);
				t_s15[i] <= fp_round(a_s14[i]);
			end
			dz_s12 <= t_s11[2];
			dz_s13 <= dz_s12;
			dz_s14 <= dz_s13;
			dz_s15 <= dz_s14;
			x_s16  <= fp_mul_a(t_s15[0], width_q);
			y_s16  <= fp_add_a(FP_ONE, {~t_s15[1][31], t_s15[1][30:0]});
			dz_s16 <= dz_s15;
			x_s17  <= fp_round(x_s16);
			y_s17  <= fp_round(y_s16);
			dz_s17 <= dz_s16;
			x_s18  <= x_s17;
			y_s18  <= fp_mul_a(y_s17, height_q);
			dz_s18 <= dz_s17;
			vis_s10 <= r_vis; vis_s11 <= vis_s10; vis_s12 <= vis_s11;
			vis_s13 <= vis_s12; vis_s14 <= vis_s13; vis_s15 <= vis_s14;
			vis_s16 <= vis_s15; vis_s17 <= vis_s16; vis_s18 <= vis_s17;
			last_s10 <= r_last; last_s11 <= last_s10; last_s12 <= last_s11;
			last_s13 <= last_s12; last_s14 <= last_s13; last_s15 <= last_s14;
			last_s16 <= last_s15; last_s17 <= last_s16; last_s18 <= last_s17;
			res_q.visible <= vis_s18;
			res_q.batch_last_out <= last_s18;
			if (vis_s18) begin
				res_q.screen_x <= x_s18;
				res_q.screen_y <= fp_round(y_s18);
				res_q.depth    <= dz_s18;
			end else begin
				res_q.screen_x <= FP_ZERO;
				res_q.screen_y <= FP_ZERO;
				res_q.depth    <= FP_ZERO;
			end
		end
	end

`ifndef ASSERT_OFF
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> ($stable(v_s18) && $stable(v_s1) && $stable(rcp_valid)))
		else $error("pipeline moved while result stalled");
	a_load_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && !pt_stall && pt_data.op == OP_LOAD) |=> !v_s1)
		else $error("load word entered the point pipeline");
	a_point_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && !pt_stall && pt_data.op == OP_POINT) |=> v_s1)
		else $error("accepted point word lost");
	a_invisible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.visible) |-> (res_data.screen_x == FP_ZERO
		&& res_data.screen_y == FP_ZERO && res_data.depth == FP_ZERO))
		else $error("invisible point with nonzero coordinates");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_vertex_perspective_projection.sv =====
// Testbench for vertex_perspective_projection: drives load and point words,
// predicts each projected point in double precision rounded to single, and
// checks every result word in order. Depends on vpp_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_vertex_perspective_projection;
	import vpp_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic pt_valid;
	logic pt_stall;
	in_word_t pt_data;
	logic res_valid;
	logic res_stall;
	out_word_t res_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] mat[16];
	logic [31:0] vp_width;
	logic [31:0] vp_height;
	logic [31:0] wclip;
	out_word_t pending_q[$];
	int n_mismatch;
	int idle_cycles;
	bit fast;
	bit hold_req;

	vertex_perspective_projection dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt_data(pt_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic bit is_nan(logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic real f2r(logic [31:0] b);
		real r;
		if (b[30:23] == 8'h00) begin
			r = real'(b[22:0]) * 2.0 ** (-149);
			return b[31] ? -r : r;
		end
		return $bitstoreal({b[31], (b[30:23] == 8'hFF) ? 11'h7FF : 11'(b[30:23]) + 11'd896,
			b[22:0], 29'd0});
	endfunction

	// round to nearest even at single precision, subnormals kept
	function automatic logic [31:0] r2f(real r);
		logic [63:0] d, full, m, rem, half;
		int fe, sh;
		logic [30:0] base;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? FP_QNAN : {d[63], 8'hFF, 23'd0};
		if (d[62:52] == 11'h000) return {d[63], 31'd0};
		fe = int'(d[62:52]) - 896;
		if (fe >= 255) return {d[63], 8'hFF, 23'd0};
		sh = 29 + ((fe < 1) ? 1 - fe : 0);
		if (sh > 54) return {d[63], 31'd0};
		full = {11'd0, 1'b1, d[51:0]};
		m = full >> sh;
		rem = full & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		base = (fe >= 1) ? {8'(fe), m[22:0]} : m[30:0];
		if (rem > half || (rem == half && m[0])) base = base + 31'd1;
		return {d[63], base};
	endfunction

	function automatic real rnd(real r);
		return f2r(r2f(r));
	endfunction

	function automatic out_word_t project_point(in_word_t w);
		real x, y, z, iw, t;
		real c[4];
		logic [31:0] cwb;
		out_word_t o;
		x = f2r(w.point_x);
		y = f2r(w.point_y);
		z = f2r(w.point_z);
		for (int r = 0; r < 4; r++) begin
			c[r] = rnd(rnd(rnd(rnd(f2r(mat[r]) * x) + rnd(f2r(mat[4 + r]) * y))
				+ rnd(f2r(mat[8 + r]) * z)) + f2r(mat[12 + r]));
		end
		o = '0;
		o.batch_last_out = w.batch_last_in;
		cwb = r2f(c[3]);
		if (!is_nan(cwb) && !is_nan(wclip) && c[3] > f2r(wclip)) begin
			if (c[3] == 0.0)
				iw = $bitstoreal(cwb[31] ? 64'hFFF0_0000_0000_0000 : 64'h7FF0_0000_0000_0000);
			else
				iw = rnd(1.0 / c[3]);
			t = rnd(rnd(rnd(c[0] * iw) * 0.5) + 0.5);
			o.screen_x = r2f(t * f2r(vp_width));
			t = rnd(1.0 - rnd(rnd(rnd(c[1] * iw) * 0.5) + 0.5));
			o.screen_y = r2f(t * f2r(vp_height));
			o.depth = r2f(c[2] * iw);
			o.visible = 1'b1;
		end
		return o;
	endfunction

	function automatic logic [31:0] rfloat(int spread);
		return {1'($urandom), 8'(127 - spread + $urandom_range(0, 2 * spread)),
			23'($urandom)};
	endfunction

	function automatic in_word_t load_word(logic [3:0] idx, logic [31:0] val);
		in_word_t w;
		w = $bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
		w.op = OP_LOAD;
		w.matrix_index = idx;
		w.matrix_value = val;
		return w;
	endfunction

	function automatic in_word_t point_word(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic last);
		in_word_t w;
		w = $bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
		w.op = OP_POINT;
		w.point_x = x;
		w.point_y = y;
		w.point_z = z;
		w.batch_last_in = last;
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		int g;
		logic s;
		g = fast ? 0 : $urandom_range(0, 8);
		if (g > 0) begin
			pt_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pt_valid <= 1'b1;
		pt_data <= w;
		do begin
			@(negedge clk);
			s = pt_stall;
			@(posedge clk);
		end while (s);
		if (w.op == OP_LOAD) mat[w.matrix_index] = w.matrix_value;
		else pending_q.push_back(project_point(w));
	endtask

	// drop valid, wait for all results and let the pipeline empty
	task automatic quiesce();
		pt_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			CFG_WIDTH: vp_width = v;
			CFG_HEIGHT: vp_height = v;
			CFG_WCLIP: wclip = v;
			default: ;
		endcase
	endtask

	task automatic set_view(logic [31:0] wv, logic [31:0] hv, logic [31:0] cv);
		cfg_write(CFG_WIDTH, wv);
		cfg_write(CFG_HEIGHT, hv);
		cfg_write(CFG_WCLIP, cv);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_random_matrix();
		for (int i = 0; i < 16; i++) send_word(load_word(4'(i), rfloat(3)));
	endtask

	task automatic send_random_word();
		int p;
		p = $urandom_range(0, 99);
		if (p < 8) send_word(load_word(4'($urandom), rfloat(3)));
		else if (p < 10) send_word(load_word(4'($urandom), $urandom));
		else if (p < 15)
			send_word(point_word($urandom, $urandom, $urandom, 1'($urandom)));
		else
			send_word(point_word(rfloat(6), rfloat(6), rfloat(6), 1'($urandom)));
	endtask

	task automatic test_directed();
		logic [31:0] persp[16];
		set_view(32'h4420_0000, 32'h43F0_0000, FP_ZERO);
		persp = '{default: FP_ZERO};
		persp[0] = FP_ONE;
		persp[5] = FP_ONE;
		persp[10] = FP_ONE;
		persp[11] = 32'hBF80_0000;
		for (int i = 0; i < 16; i++) send_word(load_word(4'(i), persp[i]));
		send_word(point_word(FP_ZERO, FP_ZERO, 32'hBF80_0000, 1'b0));
		send_word(point_word(FP_ONE, 32'hBF80_0000, 32'hC000_0000, 1'b1));
		send_word(point_word(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'hBF80_0000, 1'b0));
		send_word(point_word(32'h0000_0001, 32'h8000_0001, 32'hC000_0000, 1'b0));
		send_word(point_word(FP_HALF, FP_HALF, FP_ONE, 1'b0));
		send_word(point_word(FP_ONE, FP_ONE, 32'h7FC0_0001, 1'b0));
		send_word(point_word(FP_ONE, FP_ONE, 32'hFF80_0000, 1'b0));
		send_word(point_word(32'h7F80_0000, FP_ONE, 32'hBF80_0000, 1'b1));
		send_word(point_word(FP_ONE, FP_ONE, 32'h8000_0000, 1'b0));
		send_word(point_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
		quiesce();
		// zero clip w above a negative threshold
		set_view(32'h4420_0000, 32'h43F0_0000, 32'hBF80_0000);
		send_word(point_word(FP_ZERO, FP_ONE, 32'h8000_0000, 1'b1));
		send_word(point_word(FP_ONE, FP_ZERO, FP_ZERO, 1'b0));
		quiesce();
	endtask

	task automatic test_config_sweep();
		logic [31:0] vw[6], vh[6], vc[6];
		vw = '{FP_ZERO, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, $urandom, 32'h4420_0000};
		vh = '{FP_ZERO, 32'hFFFF_FFFF, 32'hFF7F_FFFF, 32'h8000_0001, $urandom, 32'h43F0_0000};
		vc = '{FP_ZERO, 32'hFFFF_FFFF, 32'hFF80_0000, 32'h7F7F_FFFF, $urandom, 32'h3C23_D70A};
		for (int k = 0; k < 6; k++) begin
			set_view(vw[k], vh[k], vc[k]);
			load_random_matrix();
			repeat (60) send_random_word();
			quiesce();
		end
	endtask

	task automatic test_random_stream();
		set_view(32'h44F0_0000, 32'h4487_0000, 32'h3A83_126F);
		load_random_matrix();
		for (int b = 0; b < 12; b++) begin
			fast = ($urandom_range(0, 3) == 0);
			repeat (100) send_random_word();
		end
		fast = 1'b0;
		quiesce();
	endtask

	task automatic test_backpressure();
		fast = 1'b1;
		hold_req = 1'b1;
		repeat (80) send_word(point_word(rfloat(4), rfloat(4), rfloat(4), 1'($urandom)));
		fast = 1'b0;
		// hold the sender until every result is back
		pt_valid <= 1'b0;
		wait (pending_q.size() == 0);
		@(posedge clk);
		repeat (20) send_random_word();
		quiesce();
	endtask

	// result side: random stall per word, one long hold on request
	initial begin
		int g;
		logic v;
		out_word_t d, e;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			g = hold_req ? LONG_HOLD : (fast ? 0 : $urandom_range(0, 8));
			hold_req = 1'b0;
			if (g > 0) begin
				res_stall <= 1'b1;
				repeat (g) @(posedge clk);
				res_stall <= 1'b0;
			end
			do begin
				@(negedge clk);
				v = res_valid;
				d = res_data;
				@(posedge clk);
			end while (!v);
			if (pending_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result word %h", d);
			end else begin
				e = pending_q.pop_front();
				if (d !== e) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("sx %h/%h sy %h/%h dz %h/%h vis %b/%b last %b/%b (exp/act)",
							e.screen_x, d.screen_x, e.screen_y, d.screen_y, e.depth, d.depth,
							e.visible, d.visible, e.batch_last_out, d.batch_last_out);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (pt_valid && !pt_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("vertex_perspective_projection: mismatch");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pt_valid = 1'b0;
		pt_data = '0;
		res_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vp_width = '0;
		vp_height = '0;
		wclip = '0;
		mat = '{default: '0};
		n_mismatch = 0;
		idle_cycles = 0;
		fast = 1'b0;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random_stream();
		test_backpressure();
		if (n_mismatch == 0) $display("vertex_perspective_projection: match");
		else $display("vertex_perspective_projection: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/vpp_pkg.sv
sv/vpp_recip.sv
sv/vertex_perspective_projection.sv
tb/sv/tb_vertex_perspective_projection.sv
